>>> hdl/assert_macros.svh
// Assertion macros used by the datapath of the extent set core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// A property that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// An implication checked in the same cycle outside reset.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(name, clk, rst, prop)
`define ASSERT_IMPLY(name, clk, rst, ante, cons)
`endif
`endif

>>> hdl/ess_pkg.sv
// Types and codes shared by the extent set controller, datapath and top level.
`timescale 1ns / 1ps
package ess_pkg;

   typedef enum logic [1:0] {
      MODE_LOOKUP     = 2'd0,
      MODE_INSERT_NEW = 2'd1,
      MODE_INSERT_EXT = 2'd2,
      MODE_REMOVE     = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_OVERLAP  = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_FULL     = 3'd3,
      ST_INVALID  = 3'd4
   } status_type;

   typedef struct packed {
      mode_type    mode;
      logic [63:0] range_start;
      logic [63:0] range_len;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] found_start;
      logic [63:0] found_len;
      logic [6:0]  extent_count;
   } rsp_type;

   // One table entry, held as first unit and end (one past the last unit).
   typedef struct packed {
      logic [63:0] first;
      logic [63:0] last;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic scan_rd;
      logic scan_ev;
      logic plan;
      logic mv_rd;
      logic mv_wr;
      logic wr_a;
      logic wr_b;
      logic respond;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic mv_done;
      logic wa_en;
      logic wb_en;
   } stat_type;

endpackage

>>> hdl/ess_ctrl.sv
// Controller state machine that sequences the scan, shift and write phases.
`timescale 1ns / 1ps
module ess_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ess_pkg::stat_type stat,
   output ess_pkg::cmd_type  cmd
);
   import ess_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_SCAN_RD = 9'b000000010,
      S_SCAN_EV = 9'b000000100,
      S_PLAN    = 9'b000001000,
      S_SHIFT   = 9'b000010000,
      S_MV_WR   = 9'b000100000,
      S_WR_A    = 9'b001000000,
      S_WR_B    = 9'b010000000,
      S_RESP    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (stat.scan_done) begin
               state_in = S_PLAN;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            cmd.scan_ev = 1'b1;
            state_in    = S_SCAN_RD;
         end
         S_PLAN: begin
            cmd.plan = 1'b1;
            state_in = S_SHIFT;
         end
         S_SHIFT: begin
            if (stat.mv_done) begin
               state_in = S_WR_A;
            end else begin
               cmd.mv_rd = 1'b1;
               state_in  = S_MV_WR;
            end
         end
         S_MV_WR: begin
            cmd.mv_wr = 1'b1;
            state_in  = S_SHIFT;
         end
         S_WR_A: begin
            cmd.wr_a = stat.wa_en;
            state_in = S_WR_B;
         end
         S_WR_B: begin
            cmd.wr_b = stat.wb_en;
            state_in = S_RESP;
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> hdl/ess_dp.sv
// Datapath: extent table memory, scan accumulators, plan registers and result.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ess_dp #(
   parameter int MAX_EXTENTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  ess_pkg::req_type  req_data,
   input  ess_pkg::cmd_type  cmd,
   output ess_pkg::stat_type stat,
   output logic             rsp_valid,
   output ess_pkg::rsp_type  rsp_data
);
   import ess_pkg::*;

   localparam int CW = $clog2(MAX_EXTENTS + 1);
   localparam int AW = $clog2(MAX_EXTENTS);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_EXTENTS);

   // Table memory and its registered read data.
   entry_type mem [MAX_EXTENTS];
   entry_type rd_data_ff;

   // Request beat.
   mode_type    mode_ff;
   logic [63:0] s_ff, e_ff;
   logic        inv_ff;
   logic [64:0] sum;

   // Control counters.
   logic [CW-1:0] count_ff, idx_ff;

   // Scan accumulators.
   logic          ovl_found_ff, lo_found_ff, rm_found_ff;
   logic [63:0]   ovl_first_ff, ovl_last_ff;
   logic [CW-1:0] lo_idx_ff, hi_ff, rm_idx_ff;
   logic [63:0]   lo_first_ff, hi_last_ff, rm_first_ff, rm_last_ff;

   // Plan registers.
   status_type    st_ff, st_in;
   logic [63:0]   fs_ff, fs_in, fl_ff, fl_in;
   logic          mv_en_ff, mv_en_in, mv_up_ff, mv_up_in;
   logic [CW-1:0] mv_at_ff, mv_at_in, mv_n_ff, mv_n_in, mv_dst_ff, mv_dst_in;
   logic          wa_en_ff, wa_en_in, wb_en_ff, wb_en_in;
   logic [CW-1:0] wa_addr_ff, wa_addr_in, wb_addr_ff, wb_addr_in;
   entry_type     wa_ent_ff, wa_ent_in, wb_ent_ff, wb_ent_in;

   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic          ovl_hit;
   logic [CW-1:0] lo_v, merge_n, mv_src;
   logic          full;
   logic [63:0]   m_first, m_last;

   // Memory ports: one write and one registered read a cycle.
   logic          we, re;
   logic [CW-1:0] waddr, raddr;
   entry_type     wdata;

   assign sum = {1'b0, req_data.range_start} + {1'b0, req_data.range_len};
   assign ovl_hit = (rd_data_ff.last > s_ff) && (rd_data_ff.first < e_ff);
   assign mv_src = mv_up_ff ? (mv_dst_ff - CW'(1)) : (mv_dst_ff + mv_n_ff);

   assign stat.scan_done = (idx_ff >= count_ff);
   assign stat.mv_done   = !mv_en_ff ||
                           (mv_up_ff ? (mv_dst_ff <= mv_at_ff)
                                     : ((mv_dst_ff + mv_n_ff) >= count_ff));
   assign stat.wa_en     = wa_en_ff;
   assign stat.wb_en     = wb_en_ff;

   // Read and write port selection.
   always_comb begin
      re    = cmd.scan_rd || cmd.mv_rd;
      raddr = cmd.scan_rd ? idx_ff : mv_src;
      we    = cmd.mv_wr || cmd.wr_a || cmd.wr_b;
      waddr = mv_dst_ff;
      wdata = rd_data_ff;
      if (cmd.wr_a) begin
         waddr = wa_addr_ff;
         wdata = wa_ent_ff;
      end else if (cmd.wr_b) begin
         waddr = wb_addr_ff;
         wdata = wb_ent_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr[AW-1:0]] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem[raddr[AW-1:0]];
      end
   end

   // Plan the change to the table from the scan results.
   always_comb begin
      lo_v     = lo_found_ff ? lo_idx_ff : count_ff;
      full     = (count_ff >= MAX_C);
      merge_n  = hi_ff - lo_v - CW'(1);
      m_first  = (lo_first_ff < s_ff) ? lo_first_ff : s_ff;
      m_last   = (hi_last_ff > e_ff) ? hi_last_ff : e_ff;
      st_in    = ST_OK;
      fs_in    = '0;
      fl_in    = '0;
      mv_en_in = 1'b0;
      mv_up_in = 1'b0;
      mv_at_in = '0;
      mv_n_in  = '0;
      wa_en_in = 1'b0;
      wb_en_in = 1'b0;
      wa_addr_in = '0;
      wb_addr_in = '0;
      wa_ent_in  = '{first: s_ff, last: e_ff};
      wb_ent_in  = '{first: s_ff, last: e_ff};
      if (inv_ff) begin
         st_in = ST_INVALID;
      end else begin
         case (mode_ff)
            MODE_LOOKUP: begin
               if (ovl_found_ff) begin
                  fs_in = ovl_first_ff;
                  fl_in = ovl_last_ff - ovl_first_ff;
               end else begin
                  st_in = ST_NOTFOUND;
               end
            end
            MODE_INSERT_NEW, MODE_INSERT_EXT: begin
               if (mode_ff == MODE_INSERT_NEW && ovl_found_ff) begin
                  st_in = ST_OVERLAP;
               end else if (lo_v == hi_ff) begin
                  if (full) begin
                     st_in = ST_FULL;
                  end else begin
                     mv_en_in   = 1'b1;
                     mv_up_in   = 1'b1;
                     mv_at_in   = lo_v;
                     wa_en_in   = 1'b1;
                     wa_addr_in = lo_v;
                  end
               end else begin
                  wa_en_in   = 1'b1;
                  wa_addr_in = lo_v;
                  wa_ent_in  = '{first: m_first, last: m_last};
                  mv_en_in   = (merge_n != '0);
                  mv_at_in   = lo_v + CW'(1);
                  mv_n_in    = merge_n;
               end
            end
            MODE_REMOVE: begin
               if (!rm_found_ff) begin
                  st_in = ST_NOTFOUND;
               end else if (rm_first_ff < s_ff && rm_last_ff > e_ff) begin
                  if (full) begin
                     st_in = ST_FULL;
                  end else begin
                     mv_en_in   = 1'b1;
                     mv_up_in   = 1'b1;
                     mv_at_in   = rm_idx_ff + CW'(1);
                     wa_en_in   = 1'b1;
                     wa_addr_in = rm_idx_ff + CW'(1);
                     wa_ent_in  = '{first: e_ff, last: rm_last_ff};
                     wb_en_in   = 1'b1;
                     wb_addr_in = rm_idx_ff;
                     wb_ent_in  = '{first: rm_first_ff, last: s_ff};
                  end
               end else if (rm_first_ff < s_ff) begin
                  wa_en_in   = 1'b1;
                  wa_addr_in = rm_idx_ff;
                  wa_ent_in  = '{first: rm_first_ff, last: s_ff};
               end else if (rm_last_ff > e_ff) begin
                  wa_en_in   = 1'b1;
                  wa_addr_in = rm_idx_ff;
                  wa_ent_in  = '{first: e_ff, last: rm_last_ff};
               end else begin
                  mv_en_in = 1'b1;
                  mv_at_in = rm_idx_ff;
                  mv_n_in  = CW'(1);
               end
            end
            default: begin
               st_in = ST_INVALID;
            end
         endcase
      end
      mv_dst_in = mv_up_in ? count_ff : mv_at_in;
   end

   // Request beat, scan accumulators and plan registers.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff      <= req_data.mode;
         s_ff         <= req_data.range_start;
         e_ff         <= sum[63:0];
         inv_ff       <= (req_data.range_len == '0) || sum[64];
         ovl_found_ff <= 1'b0;
         lo_found_ff  <= 1'b0;
         rm_found_ff  <= 1'b0;
         hi_ff        <= '0;
      end
      if (cmd.scan_ev) begin
         if (ovl_hit && !ovl_found_ff) begin
            ovl_found_ff <= 1'b1;
            ovl_first_ff <= rd_data_ff.first;
            ovl_last_ff  <= rd_data_ff.last;
         end
         if (rd_data_ff.last >= s_ff && !lo_found_ff) begin
            lo_found_ff <= 1'b1;
            lo_idx_ff   <= idx_ff;
            lo_first_ff <= rd_data_ff.first;
         end
         if (rd_data_ff.first <= e_ff) begin
            hi_ff      <= idx_ff + CW'(1);
            hi_last_ff <= rd_data_ff.last;
         end
         if (rd_data_ff.first <= s_ff && rd_data_ff.last >= e_ff && !rm_found_ff) begin
            rm_found_ff <= 1'b1;
            rm_idx_ff   <= idx_ff;
            rm_first_ff <= rd_data_ff.first;
            rm_last_ff  <= rd_data_ff.last;
         end
      end
      if (cmd.plan) begin
         st_ff      <= st_in;
         fs_ff      <= fs_in;
         fl_ff      <= fl_in;
         mv_up_ff   <= mv_up_in;
         mv_at_ff   <= mv_at_in;
         mv_n_ff    <= mv_n_in;
         wa_addr_ff <= wa_addr_in;
         wa_ent_ff  <= wa_ent_in;
         wb_addr_ff <= wb_addr_in;
         wb_ent_ff  <= wb_ent_in;
      end
      if (cmd.plan) begin
         mv_dst_ff <= mv_dst_in;
      end else if (cmd.mv_wr) begin
         mv_dst_ff <= mv_up_ff ? (mv_dst_ff - CW'(1)) : (mv_dst_ff + CW'(1));
      end
      if (cmd.respond) begin
         rsp_ff.status      <= st_ff;
         rsp_ff.found_start <= fs_ff;
         rsp_ff.found_len   <= fl_ff;
         rsp_ff.extent_count <= 7'(count_ff + (mv_en_ff && mv_up_ff ? CW'(1) : '0)
                                  - (mv_en_ff && !mv_up_ff ? mv_n_ff : '0));
      end
   end

   // Control state: count, scan index, plan enables and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         mv_en_ff     <= 1'b0;
         wa_en_ff     <= 1'b0;
         wb_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
         if (cmd.accept) begin
            idx_ff <= '0;
         end else if (cmd.scan_ev) begin
            idx_ff <= idx_ff + CW'(1);
         end
         if (cmd.plan) begin
            mv_en_ff <= mv_en_in;
            wa_en_ff <= wa_en_in;
            wb_en_ff <= wb_en_in;
         end
         if (cmd.respond) begin
            if (mv_en_ff && mv_up_ff) begin
               count_ff <= count_ff + CW'(1);
            end else if (mv_en_ff) begin
               count_ff <= count_ff - mv_n_ff;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= MAX_C)
   `ASSERT_IMPLY(a_scan_in_table, clock, reset, cmd.scan_ev, idx_ff < count_ff)
   `ASSERT_IMPLY(a_move_in_table, clock, reset, cmd.mv_wr, mv_dst_ff < MAX_C)

endmodule

>>> hdl/extent_set_merge_split_core.sv
// Top level of the extent set core: controller and datapath joined together.
`timescale 1ns / 1ps
// Holds up to MAX_EXTENTS disjoint extents sorted by start and serves one
// lookup, insert or remove beat at a time. A beat is taken when start is high
// and busy is low; its result appears on rsp_data for one cycle with rsp_valid
// and cannot be held off, so the receiver must take it then. A beat first scans
// the N extents held, then shifts the M entries that open or close a slot;
// both passes go through the single read port of the table memory. No
// clearing pass is needed after reset.
module extent_set_merge_split_core #(
   parameter int MAX_EXTENTS = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  ess_pkg::req_type req_data,
   output logic            rsp_valid,
   output ess_pkg::rsp_type rsp_data
);
   import ess_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ess_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   ess_dp #(
      .MAX_EXTENTS (MAX_EXTENTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
